[src/onewire_temperature_reader_defines.svh]
// ----------------------------------------------------------------------------
// onewire_temperature_reader_defines.svh
// Assertion macros shared by the one-wire temperature reader.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_TEMPERATURE_READER_DEFINES_SVH
`define ONEWIRE_TEMPERATURE_READER_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define OWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define OWT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/owt_pkg.sv]
// ----------------------------------------------------------------------------
// owt_pkg
// Shared types and constants of the one-wire temperature reader.
// ----------------------------------------------------------------------------
package owt_pkg;

  localparam int unsigned TimerBitsDef = 16;
  localparam int unsigned PhaseBits    = 16;
  localparam int unsigned TempBits     = 16;
  localparam int unsigned ApbAddrBits  = 5;
  localparam int unsigned ApbDataBits  = 32;

  // Register reset values
  localparam logic [7:0]  SkipRomRst    = 8'd204;
  localparam logic [7:0]  ConvertRst    = 8'd68;
  localparam logic [7:0]  ReadScratchRst = 8'd190;
  localparam logic [15:0] ConvWaitRst   = 16'd15000;
  localparam logic [9:0]  ResetPulseRst = 10'd480;

  // Fixed slot timings in microsecond ticks
  localparam logic [PhaseBits-1:0] PresSampleUs = 16'd70;
  localparam logic [PhaseBits-1:0] PresTailUs   = 16'd410;
  localparam logic [PhaseBits-1:0] W1LowUs      = 16'd5;
  localparam logic [PhaseBits-1:0] W1RelUs      = 16'd55;
  localparam logic [PhaseBits-1:0] W0LowUs      = 16'd60;
  localparam logic [PhaseBits-1:0] W0RelUs      = 16'd5;
  localparam logic [PhaseBits-1:0] RecoveryUs   = 16'd2;
  localparam logic [PhaseBits-1:0] RdLowUs      = 16'd2;
  localparam logic [PhaseBits-1:0] RdSampleUs   = 16'd10;
  localparam logic [PhaseBits-1:0] RdTailUs     = 16'd50;

  typedef enum logic [2:0] {
    REG_SKIP_ROM    = 3'd0,
    REG_CONVERT     = 3'd1,
    REG_READ_SCRATCH = 3'd2,
    REG_CONV_WAIT   = 3'd3,
    REG_RESET_PULSE = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  skip_rom_command;
    logic [7:0]  convert_command;
    logic [7:0]  read_scratch_command;
    logic [15:0] conversion_wait_us;
    logic [9:0]  reset_pulse_us;
  } cfg_t;

  typedef struct packed {
    logic                       drive_low;
    logic                       busy_res;
    logic                       result_valid;
    logic                       sensor_absent;
    logic signed [TempBits-1:0] temperature_raw;
  } res_t;

endpackage

[src/owt_if.sv]
// ----------------------------------------------------------------------------
// owt_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface owt_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic line_level;

  modport source (output valid, output req_type, output line_level, input ready);
  modport sink   (input valid, input req_type, input line_level, output ready);
endinterface

interface owt_res_if;
  logic                                valid;
  logic                                ready;
  logic                                drive_low;
  logic                                busy_res;
  logic                                result_valid;
  logic                                sensor_absent;
  logic signed [owt_pkg::TempBits-1:0] temperature_raw;

  modport source (output valid, output drive_low, output busy_res, output result_valid,
                  output sensor_absent, output temperature_raw, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input result_valid,
                  input sensor_absent, input temperature_raw, output ready);
endinterface

[src/owt_regs.sv]
// ----------------------------------------------------------------------------
// owt_regs
// APB configuration registers.
// ----------------------------------------------------------------------------
module owt_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [owt_pkg::ApbAddrBits-1:0]    paddr,
  input  logic [owt_pkg::ApbDataBits-1:0]    pwdata,
  output logic [owt_pkg::ApbDataBits-1:0]    prdata,
  output logic                               pready,
  output owt_pkg::cfg_t                      cfg_o
);
  import owt_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ApbAddrBits-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.skip_rom_command     <= SkipRomRst;
      cfg_q.convert_command      <= ConvertRst;
      cfg_q.read_scratch_command <= ReadScratchRst;
      cfg_q.conversion_wait_us   <= ConvWaitRst;
      cfg_q.reset_pulse_us       <= ResetPulseRst;
    end else if (wr_en) begin
      case (idx)
        REG_SKIP_ROM:     cfg_q.skip_rom_command     <= pwdata[7:0];
        REG_CONVERT:      cfg_q.convert_command      <= pwdata[7:0];
        REG_READ_SCRATCH: cfg_q.read_scratch_command <= pwdata[7:0];
        REG_CONV_WAIT:    cfg_q.conversion_wait_us   <= pwdata[15:0];
        REG_RESET_PULSE:  cfg_q.reset_pulse_us       <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SKIP_ROM:     prdata = ApbDataBits'(cfg_q.skip_rom_command);
      REG_CONVERT:      prdata = ApbDataBits'(cfg_q.convert_command);
      REG_READ_SCRATCH: prdata = ApbDataBits'(cfg_q.read_scratch_command);
      REG_CONV_WAIT:    prdata = ApbDataBits'(cfg_q.conversion_wait_us);
      REG_RESET_PULSE:  prdata = ApbDataBits'(cfg_q.reset_pulse_us);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[src/owt_core.sv]
// ----------------------------------------------------------------------------
// owt_core
// Bus sequencer: one microsecond tick or start request per enabled cycle.
// ----------------------------------------------------------------------------
module owt_core #(
  parameter int unsigned TIMER_BITS = owt_pkg::TimerBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          req_type_i,
  input  logic          line_level_i,
  input  owt_pkg::cfg_t cfg_i,
  output owt_pkg::res_t res_o
);
  import owt_pkg::*;

  localparam int unsigned CmpBits = (TIMER_BITS > PhaseBits) ? TIMER_BITS : PhaseBits;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_RST1  = 4'd1,
    ST_SKIP1 = 4'd2,
    ST_CONV  = 4'd3,
    ST_WAIT  = 4'd4,
    ST_RST2  = 4'd5,
    ST_SKIP2 = 4'd6,
    ST_RDCMD = 4'd7,
    ST_RLSB  = 4'd8,
    ST_RMSB  = 4'd9
  } step_e;

  localparam logic [1:0] SlotLow  = 2'd0;
  localparam logic [1:0] SlotMid  = 2'd1;
  localparam logic [1:0] SlotTail = 2'd2;

  step_e                 step_q, step_d;
  logic [1:0]            slot_q, slot_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [2:0]            bit_q, bit_d;
  logic [7:0]            shift_q, shift_d;
  logic [7:0]            low_q, low_d;
  logic                  pres_q, pres_d;

  logic                 is_rst, is_wr, is_rd, cmd_bit, drive_now;
  logic [7:0]           cmd;
  logic [PhaseBits-1:0] len, last;
  logic [CmpBits-1:0]   last_cmp, mask_cmp, last_clip;
  logic                 phase_end;

  assign is_rst = (step_q inside {ST_RST1, ST_RST2});
  assign is_wr  = (step_q inside {ST_SKIP1, ST_CONV, ST_SKIP2, ST_RDCMD});
  assign is_rd  = (step_q inside {ST_RLSB, ST_RMSB});

  always_comb begin
    case (step_q)
      ST_CONV:  cmd = cfg_i.convert_command;
      ST_RDCMD: cmd = cfg_i.read_scratch_command;
      default:  cmd = cfg_i.skip_rom_command;
    endcase
  end
  assign cmd_bit = cmd[bit_q];

  // phase length in ticks, zero-length config phases last one tick
  always_comb begin
    len = PhaseBits'(1);
    if (step_q == ST_WAIT) begin
      len = (cfg_i.conversion_wait_us != '0) ? cfg_i.conversion_wait_us : PhaseBits'(1);
    end else if (is_rst) begin
      if (slot_q == SlotLow) begin
        len = (cfg_i.reset_pulse_us != '0) ? PhaseBits'(cfg_i.reset_pulse_us)
                                           : PhaseBits'(1);
      end else if (slot_q == SlotMid) begin
        len = PresSampleUs;
      end else begin
        len = PresTailUs;
      end
    end else if (is_wr) begin
      if (slot_q == SlotLow)      len = cmd_bit ? W1LowUs : W0LowUs;
      else if (slot_q == SlotMid) len = cmd_bit ? W1RelUs : W0RelUs;
      else                        len = RecoveryUs;
    end else if (is_rd) begin
      if (slot_q == SlotLow)      len = RdLowUs;
      else if (slot_q == SlotMid) len = RdSampleUs;
      else                        len = RdTailUs;
    end
  end

  // clip the terminal count to what the timer can hold
  assign last      = len - PhaseBits'(1);
  assign last_cmp  = CmpBits'(last);
  assign mask_cmp  = CmpBits'({TIMER_BITS{1'b1}});
  assign last_clip = (last_cmp > mask_cmp) ? mask_cmp : last_cmp;
  assign phase_end = (CmpBits'(timer_q) == last_clip);

  assign drive_now = !(step_q inside {ST_IDLE, ST_WAIT}) && (slot_q == SlotLow);

  always_comb begin
    step_d  = step_q;
    slot_d  = slot_q;
    timer_d = timer_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    low_d   = low_q;
    pres_d  = pres_q;
    res_o   = '0;

    if (req_type_i) begin
      if (step_q == ST_IDLE) begin
        step_d  = ST_RST1;
        slot_d  = SlotLow;
        timer_d = '0;
        bit_d   = '0;
        pres_d  = 1'b0;
        res_o.drive_low = 1'b1;
      end else begin
        res_o.drive_low = drive_now;
      end
    end else if (step_q != ST_IDLE) begin
      res_o.drive_low = drive_now;
      if (phase_end) begin
        if (slot_q == SlotMid && is_rst) pres_d = !line_level_i;
        if (slot_q == SlotMid && is_rd && line_level_i) shift_d = shift_q | (8'd1 << bit_q);
        timer_d = '0;
        if (step_q == ST_WAIT) begin
          step_d = ST_RST2;
          slot_d = SlotLow;
          bit_d  = '0;
          pres_d = 1'b0;
        end else if (slot_q != SlotTail) begin
          slot_d = slot_q + 2'd1;
        end else begin
          slot_d = SlotLow;
          if (is_rst) begin
            if (!pres_q) begin
              // no presence pulse: abort
              step_d = ST_IDLE;
              res_o.result_valid  = 1'b1;
              res_o.sensor_absent = 1'b1;
            end else begin
              step_d = (step_q == ST_RST1) ? ST_SKIP1 : ST_SKIP2;
              bit_d  = '0;
            end
          end else if (bit_q != 3'd7) begin
            bit_d = bit_q + 3'd1;
          end else begin
            bit_d = '0;
            case (step_q)
              ST_SKIP1: step_d = ST_CONV;
              ST_CONV:  step_d = ST_WAIT;
              ST_SKIP2: step_d = ST_RDCMD;
              ST_RDCMD: begin
                shift_d = '0;
                step_d  = ST_RLSB;
              end
              ST_RLSB: begin
                low_d   = shift_q;
                shift_d = '0;
                step_d  = ST_RMSB;
              end
              ST_RMSB: begin
                res_o.temperature_raw = {shift_q, low_q};
                res_o.result_valid    = 1'b1;
                step_d                = ST_IDLE;
              end
              default: step_d = ST_IDLE;
            endcase
          end
        end
      end else begin
        timer_d = timer_q + TIMER_BITS'(1);
      end
    end
    res_o.busy_res = (step_d != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_IDLE;
      slot_q  <= SlotLow;
      timer_q <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      low_q   <= '0;
      pres_q  <= 1'b0;
    end else if (en_i) begin
      step_q  <= step_d;
      slot_q  <= slot_d;
      timer_q <= timer_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      low_q   <= low_d;
      pres_q  <= pres_d;
    end
  end

endmodule

[src/onewire_temperature_reader.sv]
// ----------------------------------------------------------------------------
// onewire_temperature_reader: one-wire master doing a full temperature read.
// Items pass the input register, then the result register; a result stall
//   holds the item in the input register.
// Throughput: 1 item per cycle while results are taken; combinational step.
// Reset: rst_ni async low; sequencer idle, registers to defaults, stages empty.
// ----------------------------------------------------------------------------
`include "onewire_temperature_reader_defines.svh"

module onewire_temperature_reader #(
  parameter int unsigned TIMER_BITS = owt_pkg::TimerBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  owt_req_if.sink                         req_i,
  owt_res_if.source                       res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [owt_pkg::ApbAddrBits-1:0] paddr,
  input  logic [owt_pkg::ApbDataBits-1:0] pwdata,
  output logic [owt_pkg::ApbDataBits-1:0] prdata,
  output logic                            pready
);
  import owt_pkg::*;

  cfg_t cfg;
  res_t core_res;

  // input stage: one tick or start request waiting for the sequencer
  logic in_v_q;
  logic in_req_q;
  logic in_line_q;

  // result stage: holds a finished item until the sink takes it
  logic out_v_q;
  res_t out_q;

  logic out_free;  // result stage can take a new item this cycle
  logic core_en;   // sequencer consumes the buffered item
  logic in_acc;

  assign out_free    = !out_v_q || res_o.ready;
  assign core_en     = in_v_q && out_free;
  assign req_i.ready = !in_v_q || out_free;
  assign in_acc      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_acc) begin
      in_v_q <= 1'b1;
    end else if (core_en) begin
      in_v_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_req_q  <= req_i.req_type;
      in_line_q <= req_i.line_level;
    end
  end

  owt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer state advances only when the buffered item is consumed
  owt_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (core_en),
    .req_type_i   (in_req_q),
    .line_level_i (in_line_q),
    .cfg_i        (cfg),
    .res_o        (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (core_en) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_en) out_q <= core_res;
  end

  assign res_o.valid           = out_v_q;
  assign res_o.drive_low       = out_q.drive_low;
  assign res_o.busy_res        = out_q.busy_res;
  assign res_o.result_valid    = out_q.result_valid;
  assign res_o.sensor_absent   = out_q.sensor_absent;
  assign res_o.temperature_raw = out_q.temperature_raw;

  // a blocked input item stays buffered
  `OWT_ASSERT(a_in_hold, in_v_q && !out_free |=> in_v_q, "input item lost while stalled")
  // every consumed item lands in the result stage
  `OWT_ASSERT(a_core_to_out, core_en |=> out_v_q, "consumed item not registered")
  // an absent sensor reports a finished sequence with zero reading
  `OWT_ASSERT(a_absent_fmt,
    out_v_q && out_q.sensor_absent |-> out_q.result_valid && !out_q.busy_res &&
    out_q.temperature_raw == '0, "bad absent-sensor result")

endmodule

[verif/owt_result_checker.sv]
// ----------------------------------------------------------------------------
// owt_result_checker
// Watches the request, result and APB ports of the one-wire temperature
// reader. It predicts every result item from its own model of the bus
// sequencer and compares the two field by field.
// ----------------------------------------------------------------------------
module owt_result_checker #(
  parameter int unsigned TIMER_BITS = owt_pkg::TimerBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  owt_req_if                              req_ch,
  owt_res_if                              res_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [owt_pkg::ApbAddrBits-1:0] paddr,
  input  logic [owt_pkg::ApbDataBits-1:0] pwdata,
  output int unsigned                     fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import owt_pkg::*;

  typedef enum logic [3:0] {
    SEQ_IDLE     = 4'd0,
    SEQ_RESET1   = 4'd1,
    SEQ_SKIP1    = 4'd2,
    SEQ_CONVERT  = 4'd3,
    SEQ_WAIT     = 4'd4,
    SEQ_RESET2   = 4'd5,
    SEQ_SKIP2    = 4'd6,
    SEQ_READ_CMD = 4'd7,
    SEQ_READ_LSB = 4'd8,
    SEQ_READ_MSB = 4'd9
  } seq_step_e;

  // slot lengths in microsecond ticks
  localparam int unsigned PresenceWaitUs = 70;
  localparam int unsigned PresenceTailUs = 410;
  localparam int unsigned OneLowUs       = 5;
  localparam int unsigned OneRelUs       = 55;
  localparam int unsigned ZeroLowUs      = 60;
  localparam int unsigned ZeroRelUs      = 5;
  localparam int unsigned RecoverUs      = 2;
  localparam int unsigned ReadLowUs      = 2;
  localparam int unsigned ReadSampleUs   = 10;
  localparam int unsigned ReadTailUs     = 50;

  localparam logic [31:0] TimerMask = 32'((64'd1 << TIMER_BITS) - 64'd1);

  cfg_t        cfg;
  seq_step_e   step;
  logic [1:0]  slot;
  logic [31:0] slot_timer;
  logic [2:0]  bit_idx;
  logic [7:0]  rx_byte;
  logic [7:0]  lsb_byte;
  logic        presence;
  res_t        predicted_steps[$];
  int unsigned mismatches;

  function automatic logic in_reset();
    return step == SEQ_RESET1 || step == SEQ_RESET2;
  endfunction

  function automatic logic in_read();
    return step == SEQ_READ_LSB || step == SEQ_READ_MSB;
  endfunction

  function automatic void begin_reset(input seq_step_e which);
    step       = which;
    slot       = 2'd0;
    slot_timer = '0;
    bit_idx    = '0;
    presence   = 1'b0;
  endfunction

  function automatic int unsigned slot_length();
    logic [7:0] cmd;
    logic       bit_val;
    cmd = cfg.skip_rom_command;
    if (step == SEQ_CONVERT) cmd = cfg.convert_command;
    else if (step == SEQ_READ_CMD) cmd = cfg.read_scratch_command;
    bit_val = cmd[bit_idx];
    case (step)
      SEQ_WAIT: begin
        return (cfg.conversion_wait_us == 16'd0) ? 1 : int'(cfg.conversion_wait_us);
      end
      SEQ_RESET1, SEQ_RESET2: begin
        if (slot == 2'd0) return (cfg.reset_pulse_us == 10'd0) ? 1 : int'(cfg.reset_pulse_us);
        return (slot == 2'd1) ? PresenceWaitUs : PresenceTailUs;
      end
      SEQ_SKIP1, SEQ_CONVERT, SEQ_SKIP2, SEQ_READ_CMD: begin
        if (slot == 2'd0) return bit_val ? OneLowUs : ZeroLowUs;
        if (slot == 2'd1) return bit_val ? OneRelUs : ZeroRelUs;
        return RecoverUs;
      end
      SEQ_READ_LSB, SEQ_READ_MSB: begin
        if (slot == 2'd0) return ReadLowUs;
        return (slot == 2'd1) ? ReadSampleUs : ReadTailUs;
      end
      default: return 1;
    endcase
  endfunction

  // master pulls the bus low in the first slot of every phase except the wait
  function automatic logic drive_level();
    if (step == SEQ_IDLE || step == SEQ_WAIT) return 1'b0;
    return slot == 2'd0;
  endfunction

  // one item through the sequencer: returns the result item it causes
  function automatic res_t master_step(input logic start, input logic line);
    res_t        out;
    logic [31:0] last;
    out = '0;
    if (start) begin
      if (step == SEQ_IDLE) begin_reset(SEQ_RESET1);
      out.drive_low = drive_level();
    end else if (step != SEQ_IDLE) begin
      out.drive_low = drive_level();
      last = slot_length() - 1;
      if (last > TimerMask) last = TimerMask;
      if (slot_timer == last) begin
        if (slot == 2'd1 && in_reset()) presence = !line;
        if (slot == 2'd1 && in_read() && line) rx_byte[bit_idx] = 1'b1;
        slot_timer = '0;
        if (step == SEQ_WAIT) begin
          begin_reset(SEQ_RESET2);
        end else if (slot < 2'd2) begin
          slot = slot + 2'd1;
        end else begin
          slot = 2'd0;
          if (in_reset()) begin
            if (!presence) begin
              step              = SEQ_IDLE;
              out.result_valid  = 1'b1;
              out.sensor_absent = 1'b1;
            end else begin
              step    = seq_step_e'(step + 4'd1);
              bit_idx = '0;
            end
          end else if (bit_idx < 3'd7) begin
            bit_idx = bit_idx + 3'd1;
          end else begin
            bit_idx = '0;
            case (step)
              SEQ_READ_LSB: begin
                lsb_byte = rx_byte;
                rx_byte  = '0;
                step     = SEQ_READ_MSB;
              end
              SEQ_READ_MSB: begin
                out.temperature_raw = {rx_byte, lsb_byte};
                out.result_valid    = 1'b1;
                step                = SEQ_IDLE;
              end
              default: begin
                if (step == SEQ_READ_CMD) rx_byte = '0;
                step = seq_step_e'(step + 4'd1);
              end
            endcase
          end
        end
      end else begin
        slot_timer = (slot_timer + 32'd1) & TimerMask;
      end
    end
    out.busy_res = step != SEQ_IDLE;
    return out;
  endfunction

  function automatic void compare_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      cfg        = '{SkipRomRst, ConvertRst, ReadScratchRst, ConvWaitRst, ResetPulseRst};
      step       = SEQ_IDLE;
      slot       = 2'd0;
      slot_timer = '0;
      bit_idx    = '0;
      rx_byte    = '0;
      lsb_byte   = '0;
      presence   = 1'b0;
      mismatches = 0;
      predicted_steps.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[ApbAddrBits-1:2]))
          REG_SKIP_ROM:     cfg.skip_rom_command     = pwdata[7:0];
          REG_CONVERT:      cfg.convert_command      = pwdata[7:0];
          REG_READ_SCRATCH: cfg.read_scratch_command = pwdata[7:0];
          REG_CONV_WAIT:    cfg.conversion_wait_us   = pwdata[15:0];
          REG_RESET_PULSE:  cfg.reset_pulse_us       = pwdata[9:0];
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready)
        predicted_steps.push_back(master_step(req_ch.req_type, req_ch.line_level));
      if (res_ch.valid && res_ch.ready) begin
        if (predicted_steps.size() == 0) begin
          mismatches++;
          $error("result item with no prediction pending");
        end else begin
          want = predicted_steps.pop_front();
          compare_field("drive_low", want.drive_low, res_ch.drive_low);
          compare_field("busy_res", want.busy_res, res_ch.busy_res);
          compare_field("result_valid", want.result_valid, res_ch.result_valid);
          compare_field("sensor_absent", want.sensor_absent, res_ch.sensor_absent);
          compare_field("temperature_raw", want.temperature_raw, res_ch.temperature_raw);
        end
      end
      // predictions still pending at the end count as failures
      fail_count <= mismatches + predicted_steps.size();
    end
  end

endmodule

[verif/tb_onewire_temperature_reader.sv]
// ----------------------------------------------------------------------------
// tb_onewire_temperature_reader
// Drives complete temperature reads through the one-wire master: start
// requests and microsecond ticks with a random bus level, under random
// command bytes and short timing written over APB (zero lengths included).
// A separate checker predicts every result item; this module makes
// stimulus, throttles both channels and gives the verdict.
// ----------------------------------------------------------------------------
module tb_onewire_temperature_reader;
  timeunit 1ns;
  timeprecision 1ps;
  import owt_pkg::*;

  // request kinds carried in req_type
  localparam logic ReqTick  = 1'b0;
  localparam logic ReqStart = 1'b1;

  // cycles without any handshake before the run is declared hung
  localparam int unsigned IdleLimit = 2000;

  // drain loop granularity and rate of spare start requests within it
  localparam int unsigned DrainBurst = 32;
  localparam int unsigned StartOdds  = 200;

  // reads keep starting until this many items have gone out
  localparam int unsigned ItemTarget = 1000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ApbAddrBits-1:0] paddr;
  logic [ApbDataBits-1:0] pwdata;
  logic [ApbDataBits-1:0] prdata;
  logic                   pready;

  owt_req_if req_ch ();
  owt_res_if res_ch ();

  int unsigned items_sent;
  int unsigned items_returned;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  int unsigned fail_count;
  logic        last_busy;

  onewire_temperature_reader dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  owt_result_checker result_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_ch     (req_ch),
    .res_ch     (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result side: ready follows windows of free flow, light and heavy
  // throttling, and short full stalls. Changes only at the falling edge.
  initial begin
    int unsigned window;
    int unsigned mode;
    res_ch.ready = 1'b0;
    forever begin
      mode   = $urandom_range(0, 5);
      window = (mode == 5) ? $urandom_range(1, 16) : $urandom_range(4, 64);
      repeat (window) begin
        @(negedge clk_i);
        case (mode)
          0, 1, 2: res_ch.ready = 1'b1;
          3:       res_ch.ready = $urandom_range(0, 3) != 0;
          4:       res_ch.ready = $urandom_range(0, 3) == 0;
          default: res_ch.ready = 1'b0;
        endcase
      end
    end
  end

  // Handshake bookkeeping and the hang watchdog, all on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) items_sent++;
      if (res_ch.valid && res_ch.ready) begin
        last_busy = res_ch.busy_res;
        items_returned++;
      end
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IdleLimit) begin
          $display("tb_onewire_temperature_reader NOT OK");
          $finish;
        end
      end
    end
  end

  // bus level for one tick: low with the given percentage
  function automatic logic bus_level(input int unsigned low_pct);
    return ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
  endfunction

  // Sends one item. Entered and left at a falling edge. The sender runs in
  // bursts; a new burst may open with a gap of idle cycles.
  task automatic push_item(input logic kind, input logic line);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    req_ch.valid      = 1'b1;
    req_ch.req_type   = kind;
    req_ch.line_level = line;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_idx_e idx, input logic [ApbDataBits-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Only called with the sequencer idle and every result item back.
  task automatic load_settings(input int unsigned skip_cmd, input int unsigned conv_cmd,
                               input int unsigned read_cmd, input int unsigned wait_us,
                               input int unsigned pulse_us);
    write_reg(REG_SKIP_ROM, skip_cmd);
    write_reg(REG_CONVERT, conv_cmd);
    write_reg(REG_READ_SCRATCH, read_cmd);
    write_reg(REG_CONV_WAIT, wait_us);
    write_reg(REG_RESET_PULSE, pulse_us);
  endtask

  // Keeps ticking until the block reports idle. Ticks go out in bursts;
  // after each burst the sender waits for every result item and looks at
  // the busy flag of the last one. A rare spare start request is mixed in:
  // ignored while busy, it opens another read when it lands on idle.
  task automatic finish_read(input int unsigned low_pct);
    do begin
      repeat (DrainBurst) begin
        push_item(($urandom_range(1, StartOdds) == 1) ? ReqStart : ReqTick,
                  bus_level(low_pct));
      end
      req_ch.valid = 1'b0;
      wait (items_returned == items_sent);
      @(negedge clk_i);
    end while (last_busy);
  endtask

  // Whole reads. The presence samples and the read slots take the random
  // bus level, so a read may end on a missing sensor or with any reading.
  task automatic run_reads(input int unsigned count, input int unsigned low_pct);
    repeat (count) begin
      push_item(ReqStart, bus_level(low_pct));
      finish_read(low_pct);
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = ReqTick;
    req_ch.line_level = 1'b0;
    items_sent        = 0;
    items_returned    = 0;
    quiet_cycles      = 0;
    burst_left        = 0;
    last_busy         = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: ticks while idle at both bus levels under reset settings.
    push_item(ReqTick, 1'b0);
    push_item(ReqTick, 1'b1);
    req_ch.valid = 1'b0;
    wait (items_returned == items_sent);
    @(negedge clk_i);

    // Zero length reset pulse and conversion wait (one tick each), all-zero
    // and all-one command bytes. A start, starts while busy (ignored), then
    // the bus held high so the presence sample finds no sensor and the read
    // aborts.
    load_settings(0, 255, 0, 0, 0);
    push_item(ReqStart, 1'b0);
    push_item(ReqStart, 1'b1);
    push_item(ReqTick, 1'b1);
    push_item(ReqTick, 1'b0);
    push_item(ReqStart, 1'b0);
    finish_read(0);

    // Random command bytes with short timing; the bus is mostly low so
    // reads often get past both presence checks.
    while (items_sent < ItemTarget) begin
      load_settings($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 200), $urandom_range(0, 60));
      run_reads(1, $urandom_range(60, 90));
    end

    req_ch.valid = 1'b0;
    wait (items_returned == items_sent);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_onewire_temperature_reader OK");
    end else begin
      $display("tb_onewire_temperature_reader NOT OK");
    end
    $finish;
  end

endmodule

[onewire_temperature_reader.f]
+incdir+src
src/owt_pkg.sv
src/owt_if.sv
src/owt_regs.sv
src/owt_core.sv
src/onewire_temperature_reader.sv
verif/owt_result_checker.sv
verif/tb_onewire_temperature_reader.sv
